@@ rtl/core/nsc_pkg.sv @@
// Package for the sentence checker: phase and kind codes, summary struct and decode helpers.
`timescale 1ns / 1ps

package nsc_pkg;

    // ASCII codes the parser reacts to
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;

    localparam logic [5:0] COMMA_MAX = 6'd63;

    // Sentence parse phase
    typedef enum logic [2:0] {
        PH_IDLE   = 3'd0,
        PH_TALKER = 3'd1,
        PH_TYPE   = 3'd2,
        PH_BODY   = 3'd3,
        PH_STAR   = 3'd4,
        PH_HEX1   = 3'd5,
        PH_HEX2   = 3'd6,
        PH_BAD    = 3'd7
    } t_phase;

    // Sentence type codes as reported
    typedef enum logic [2:0] {
        KIND_NONE = 3'd0,
        KIND_GGA  = 3'd1,
        KIND_RTK  = 3'd2,
        KIND_RMC  = 3'd3,
        KIND_GST  = 3'd4,
        KIND_HDT  = 3'd5,
        KIND_VTG  = 3'd6
    } t_kind;

    // Parser state handed to the report stage at sentence end
    typedef struct packed {
        logic        hex_done;
        logic        talker_good;
        logic [7:0]  calc_sum;
        logic [23:0] kind_chars;
        logic [2:0]  kind_length;
        logic [5:0]  comma_count;
        logic [7:0]  recv_sum;
    } t_summary;

    // Hex digit decode: bit 4 flags a valid digit, either case
    function automatic logic [4:0] hex_decode(input logic [7:0] b);
        logic [4:0] res;
        res = 5'd0;
        if (b >= 8'h30 && b <= 8'h39) begin
            res = {1'b1, b[3:0]};
        end else if ((b >= 8'h41 && b <= 8'h46) || (b >= 8'h61 && b <= 8'h66)) begin
            res = {1'b1, b[3:0] + 4'd9};
        end
        return res;
    endfunction

    // Known talkers: GP, GN, GL, WT, IN
    function automatic logic talker_known(input logic [7:0] a, input logic [7:0] b);
        return (a == 8'h47 && (b == 8'h50 || b == 8'h4E || b == 8'h4C)) ||
               (a == 8'h57 && b == 8'h54) || (a == 8'h49 && b == 8'h4E);
    endfunction

    // Type decode, only three-letter types are known
    function automatic t_kind kind_decode(input logic [23:0] chars, input logic [2:0] len);
        t_kind k;
        k = KIND_NONE;
        if (len == 3'd3) begin
            case (chars)
                24'h474741: k = KIND_GGA;
                24'h52544B: k = KIND_RTK;
                24'h524D43: k = KIND_RMC;
                24'h475354: k = KIND_GST;
                24'h484454: k = KIND_HDT;
                24'h565447: k = KIND_VTG;
                default:    k = KIND_NONE;
            endcase
        end
        return k;
    endfunction

    // Minimum field count per type; unknown types never pass
    function automatic logic [5:0] kind_minimum(input t_kind k);
        logic [5:0] m;
        case (k)
            KIND_GGA: m = 6'd12;
            KIND_RTK: m = 6'd26;
            KIND_RMC: m = 6'd10;
            KIND_GST: m = 6'd9;
            KIND_HDT: m = 6'd2;
            KIND_VTG: m = 6'd6;
            default:  m = 6'd63;
        endcase
        return m;
    endfunction

endpackage

@@ rtl/core/nsc_ifs.sv @@
// Stream interfaces for received bytes and sentence reports.
`timescale 1ns / 1ps

interface nsc_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface nsc_result_if;
    logic       valid;
    logic       ready;
    logic       format_ok;
    logic       checksum_ok;
    logic [2:0] sentence_kind;
    logic [5:0] field_total;
    logic       accepted;
    logic [7:0] computed_sum;

    modport source (output valid, output format_ok, output checksum_ok,
                    output sentence_kind, output field_total, output accepted,
                    output computed_sum, input ready);
    modport sink   (input valid, input format_ok, input checksum_ok,
                    input sentence_kind, input field_total, input accepted,
                    input computed_sum, output ready);
endinterface

@@ rtl/core/nsc_parser.sv @@
// Per-byte sentence parser: phase, running XOR, talker, type and comma tracking.
`timescale 1ns / 1ps

module nsc_parser
    import nsc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_fire,
    input  logic [7:0] i_byte,
    output logic       o_end,
    output t_summary   o_summary
);

    t_phase      r_phase, n_phase;
    logic [7:0]  r_xor, n_xor;
    logic [7:0]  r_talker_first, n_talker_first;
    logic        r_talker_good, n_talker_good;
    logic [23:0] r_kind_chars, n_kind_chars;
    logic [2:0]  r_kind_len, n_kind_len;
    logic [5:0]  r_comma, n_comma;
    logic [7:0]  r_rx_sum, n_rx_sum;

    logic       w_eol;
    logic [4:0] w_hex;

    assign w_eol = (i_byte == CH_CR) || (i_byte == CH_LF);
    assign w_hex = hex_decode(i_byte);

    // Next state for one beat
    always_comb begin
        n_phase        = r_phase;
        n_xor          = r_xor;
        n_talker_first = r_talker_first;
        n_talker_good  = r_talker_good;
        n_kind_chars   = r_kind_chars;
        n_kind_len     = r_kind_len;
        n_comma        = r_comma;
        n_rx_sum       = r_rx_sum;
        if (i_fire && (i_byte == CH_DOLLAR || (r_phase != PH_IDLE && w_eol))) begin
            // start, restart or end: clear sentence state
            n_phase        = (i_byte == CH_DOLLAR) ? PH_TALKER : PH_IDLE;
            n_xor          = 8'd0;
            n_talker_first = 8'd0;
            n_talker_good  = 1'b0;
            n_kind_chars   = 24'd0;
            n_kind_len     = 3'd0;
            n_comma        = 6'd0;
            n_rx_sum       = 8'd0;
        end else if (i_fire && r_phase != PH_IDLE) begin
            if (r_phase == PH_STAR || r_phase == PH_HEX1 ||
                r_phase == PH_HEX2 || r_phase == PH_BAD) begin
                // checksum digits after the star
                if (r_phase == PH_STAR && w_hex[4]) begin
                    n_rx_sum = {4'd0, w_hex[3:0]};
                    n_phase  = PH_HEX1;
                end else if (r_phase == PH_HEX1 && w_hex[4]) begin
                    n_rx_sum = {r_rx_sum[3:0], w_hex[3:0]};
                    n_phase  = PH_HEX2;
                end else begin
                    n_phase = PH_BAD;
                end
            end else if (i_byte == CH_STAR) begin
                n_phase = PH_STAR;
            end else begin
                n_xor = r_xor ^ i_byte;
                if (i_byte == CH_COMMA && r_comma != COMMA_MAX) begin
                    n_comma = r_comma + 6'd1;
                end
                if (r_phase == PH_TALKER) begin
                    if (r_kind_len == 3'd0) begin
                        n_talker_first = i_byte;
                        n_kind_len     = 3'd1;
                    end else begin
                        n_talker_good = talker_known(r_talker_first, i_byte);
                        n_kind_len    = 3'd0;
                        n_phase       = PH_TYPE;
                    end
                end else if (r_phase == PH_TYPE) begin
                    if (i_byte == CH_COMMA) begin
                        n_phase = PH_BODY;
                    end else if (r_kind_len < 3'd3) begin
                        n_kind_chars = {r_kind_chars[15:0], i_byte};
                        n_kind_len   = r_kind_len + 3'd1;
                    end else begin
                        n_kind_len = 3'd4;
                    end
                end
            end
        end
    end

    // Outputs: sentence end strobe and current state snapshot
    always_comb begin
        o_end                 = i_fire && w_eol && r_phase != PH_IDLE;
        o_summary.hex_done    = (r_phase == PH_HEX2);
        o_summary.talker_good = r_talker_good;
        o_summary.calc_sum    = r_xor;
        o_summary.kind_chars  = r_kind_chars;
        o_summary.kind_length = r_kind_len;
        o_summary.comma_count = r_comma;
        o_summary.recv_sum    = r_rx_sum;
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase        <= PH_IDLE;
            r_xor          <= 8'd0;
            r_talker_first <= 8'd0;
            r_talker_good  <= 1'b0;
            r_kind_chars   <= 24'd0;
            r_kind_len     <= 3'd0;
            r_comma        <= 6'd0;
            r_rx_sum       <= 8'd0;
        end else begin
            r_phase        <= n_phase;
            r_xor          <= n_xor;
            r_talker_first <= n_talker_first;
            r_talker_good  <= n_talker_good;
            r_kind_chars   <= n_kind_chars;
            r_kind_len     <= n_kind_len;
            r_comma        <= n_comma;
            r_rx_sum       <= n_rx_sum;
        end
    end

endmodule

@@ rtl/core/nsc_report.sv @@
// Sentence report stage: verdict decode and the output result register.
`timescale 1ns / 1ps

module nsc_report
    import nsc_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_end,
    input  t_summary           i_summary,
    output logic               o_free,
    nsc_result_if.source       o_res
);

    logic       r_valid, n_valid;
    logic       r_fmt, r_sum_ok, r_acc;
    logic [2:0] r_kind;
    logic [5:0] r_total;
    logic [7:0] r_calc;

    t_kind      w_kind;
    logic [5:0] w_total;
    logic       w_fmt;
    logic       w_sum_ok;
    logic       w_acc;

    // Verdict from the parser snapshot
    always_comb begin
        w_kind   = kind_decode(i_summary.kind_chars, i_summary.kind_length);
        w_total  = (i_summary.comma_count == COMMA_MAX) ? COMMA_MAX
                                                        : i_summary.comma_count + 6'd1;
        w_fmt    = i_summary.talker_good && i_summary.hex_done;
        w_sum_ok = i_summary.hex_done && (i_summary.recv_sum == i_summary.calc_sum);
        w_acc    = w_fmt && (w_kind != KIND_NONE) && (w_total >= kind_minimum(w_kind));
    end

    // Result register is free when empty or draining this cycle
    assign o_free = !r_valid || o_res.ready;

    always_comb begin
        n_valid = r_valid;
        if (i_end) begin
            n_valid = 1'b1;
        end else if (o_res.ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // Payload loads on a sentence end
    always_ff @(posedge i_clk) begin
        if (i_end) begin
            r_fmt    <= w_fmt;
            r_sum_ok <= w_sum_ok;
            r_kind   <= w_kind;
            r_total  <= w_total;
            r_acc    <= w_acc;
            r_calc   <= i_summary.calc_sum;
        end
    end

    assign o_res.valid         = r_valid;
    assign o_res.format_ok     = r_fmt;
    assign o_res.checksum_ok   = r_sum_ok;
    assign o_res.sentence_kind = r_kind;
    assign o_res.field_total   = r_total;
    assign o_res.accepted      = r_acc;
    assign o_res.computed_sum  = r_calc;

endmodule

@@ rtl/core/nmea_sentence_checker.sv @@
// Top level of the NMEA sentence checker: byte parser plus report register.
//
//  channel  | dir | payload                                   | beat
//  ---------+-----+-------------------------------------------+---------------------------
//  i_rx     | in  | rx_byte                                   | one received byte
//  o_res    | out | format_ok, checksum_ok, sentence_kind,    | one report per CR/LF that
//           |     | field_total, accepted, computed_sum       | ends an open sentence
//
// One byte per cycle while i_rx is not stalled. A byte is folded into the parser state on
// the cycle it is taken; a CR or LF loads the report register, seen in the next cycle.
// Reset (synchronous, active low) returns the parser to idle and empties the report.
// i_rx stalls only while a report is held and o_res.ready is low.
`timescale 1ns / 1ps

module nmea_sentence_checker
    import nsc_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    nsc_byte_if.sink      i_rx,
    nsc_result_if.source  o_res
);

    logic     w_fire;
    logic     w_end;
    logic     w_free;
    t_summary w_summary;

    assign i_rx.ready = w_free;
    assign w_fire     = i_rx.valid && w_free;

    nsc_parser u_parser (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_fire    (w_fire),
        .i_byte    (i_rx.rx_byte),
        .o_end     (w_end),
        .o_summary (w_summary)
    );

    nsc_report u_report (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_end     (w_end),
        .i_summary (w_summary),
        .o_free    (w_free),
        .o_res     (o_res)
    );

    // A new report only follows a sentence-ending beat
    a_report_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_res.valid) |-> $past(w_end))
        else $error("report appeared without a sentence end");

    // Acceptance requires a good format and a known type
    a_accept_fmt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && o_res.accepted |-> o_res.format_ok && (o_res.sentence_kind != KIND_NONE))
        else $error("accepted without format or type");

    // Input only stalls behind a held report
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_rx.ready |-> o_res.valid && !o_res.ready)
        else $error("input stalled with free report register");

    // Field count is never zero in a report
    a_total_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |-> o_res.field_total != 6'd0)
        else $error("zero field total reported");

endmodule

@@ tb/sv/tb_nmea_sentence_checker.sv @@
// Testbench for the NMEA sentence checker: directed sentences, then random byte streams.
`timescale 1ns / 1ps

module tb_nmea_sentence_checker;
    import nsc_pkg::*;

    localparam int unsigned CYCLE_LIMIT     = 400000;
    localparam int unsigned BYTES_PER_PHASE = 300;
    localparam int unsigned HOLD_CYCLES     = 400;
    localparam int unsigned REPORT_LIMIT    = 10;
    localparam int          DIR_N           = 23;
    // in directed text this byte stands for a NUL, which a string cannot hold
    localparam logic [7:0]  CH_NUL_MARK     = 8'h01;

    typedef struct packed {
        logic       format_ok;
        logic       checksum_ok;
        t_kind      kind;
        logic [5:0] field_total;
        logic       accepted;
        logic [7:0] computed_sum;
    } t_sentence_report;

    logic i_clk = 1'b0;
    logic i_rst_n;

    nsc_byte_if   rx_if ();
    nsc_result_if res_if ();

    nmea_sentence_checker dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rx    (rx_if),
        .o_res   (res_if)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Predictor state, mirrors the parser
    t_phase      pr_phase   = PH_IDLE;
    logic [7:0]  pr_xor     = 8'h00;
    logic [7:0]  pr_talk0   = 8'h00;
    logic        pr_talk_ok = 1'b0;
    logic [23:0] pr_chars   = 24'h0;
    logic [2:0]  pr_len     = 3'd0;
    logic [5:0]  pr_commas  = 6'd0;
    logic [7:0]  pr_rsum    = 8'h00;

    t_sentence_report expected_reports[$];
    t_sentence_report mon_pred;
    t_sentence_report mon_want;
    t_sentence_report typed_exp;
    bit               use_typed = 1'b0;

    logic [7:0]  tx_q[$];
    int unsigned snd_idle  = 0;
    int unsigned rcv_idle  = 0;
    int unsigned hold_req  = 0;
    int unsigned hold_left = 0;
    int unsigned cycles    = 0;
    int unsigned failures  = 0;
    int unsigned bytes_taken   = 0;
    int unsigned reports_seen  = 0;
    int unsigned accepted_seen = 0;
    int unsigned sum_good_seen = 0;

    string            dir_text[DIR_N];
    bit               dir_typed[DIR_N];
    t_sentence_report dir_exp[DIR_N];

    // {valid, value} of a hex digit, either case
    function automatic logic [4:0] hex_nibble(input logic [7:0] c);
        logic [7:0] v;
        v = 8'hFF;
        if (c >= "0" && c <= "9") begin
            v = c - "0";
        end else if (c >= "a" && c <= "f") begin
            v = c - "a" + 8'd10;
        end else if (c >= "A" && c <= "F") begin
            v = c - "A" + 8'd10;
        end
        return (v == 8'hFF) ? 5'd0 : {1'b1, v[3:0]};
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] nib, input bit lower);
        logic [7:0] base;
        base = lower ? 8'h61 : 8'h41;
        return (nib < 4'd10) ? (8'h30 + {4'h0, nib}) : (base + {4'h0, nib} - 8'd10);
    endfunction

    function automatic int fields_needed(input t_kind k);
        case (k)
            KIND_GGA: return 12;
            KIND_RTK: return 26;
            KIND_RMC: return 10;
            KIND_GST: return 9;
            KIND_HDT: return 2;
            KIND_VTG: return 6;
            default:  return 64;
        endcase
    endfunction

    function automatic void clear_sentence_state();
        pr_xor     = 8'h00;
        pr_talk0   = 8'h00;
        pr_talk_ok = 1'b0;
        pr_chars   = 24'h0;
        pr_len     = 3'd0;
        pr_commas  = 6'd0;
        pr_rsum    = 8'h00;
    endfunction

    // Fold one byte into the predictor; returns 1 when a sentence report is due
    function automatic bit parse_byte(input logic [7:0] b, output t_sentence_report rep);
        logic [4:0] hx;
        t_kind      k;
        logic [5:0] total;
        logic       fmt;
        rep = '0;
        if (b == CH_DOLLAR) begin
            clear_sentence_state();
            pr_phase = PH_TALKER;
            return 1'b0;
        end
        if (pr_phase == PH_IDLE) begin
            return 1'b0;
        end

        // sentence end
        if (b == CH_CR || b == CH_LF) begin
            k = KIND_NONE;
            if (pr_len == 3'd3) begin
                case (pr_chars)
                    "GGA":   k = KIND_GGA;
                    "RTK":   k = KIND_RTK;
                    "RMC":   k = KIND_RMC;
                    "GST":   k = KIND_GST;
                    "HDT":   k = KIND_HDT;
                    "VTG":   k = KIND_VTG;
                    default: k = KIND_NONE;
                endcase
            end
            total = (pr_commas == COMMA_MAX) ? COMMA_MAX : pr_commas + 6'd1;
            fmt   = pr_talk_ok && (pr_phase == PH_HEX2);
            rep.format_ok    = fmt;
            rep.checksum_ok  = (pr_phase == PH_HEX2) && (pr_rsum == pr_xor);
            rep.kind         = k;
            rep.field_total  = total;
            rep.accepted     = fmt && (k != KIND_NONE) && (int'(total) >= fields_needed(k));
            rep.computed_sum = pr_xor;
            pr_phase = PH_IDLE;
            clear_sentence_state();
            return 1'b1;
        end

        // after the star: two hex digits, anything else spoils the tail
        if (pr_phase >= PH_STAR) begin
            hx = hex_nibble(b);
            if (pr_phase == PH_STAR && hx[4]) begin
                pr_rsum  = {4'h0, hx[3:0]};
                pr_phase = PH_HEX1;
            end else if (pr_phase == PH_HEX1 && hx[4]) begin
                pr_rsum  = {pr_rsum[3:0], hx[3:0]};
                pr_phase = PH_HEX2;
            end else begin
                pr_phase = PH_BAD;
            end
            return 1'b0;
        end
        if (b == CH_STAR) begin
            pr_phase = PH_STAR;
            return 1'b0;
        end

        pr_xor = pr_xor ^ b;
        if (b == CH_COMMA && pr_commas != COMMA_MAX) begin
            pr_commas = pr_commas + 6'd1;
        end
        if (pr_phase == PH_TALKER) begin
            if (pr_len == 3'd0) begin
                pr_talk0 = b;
                pr_len   = 3'd1;
            end else begin
                pr_talk_ok = ({pr_talk0, b} == "GP") || ({pr_talk0, b} == "GN") ||
                             ({pr_talk0, b} == "GL") || ({pr_talk0, b} == "WT") ||
                             ({pr_talk0, b} == "IN");
                pr_len   = 3'd0;
                pr_phase = PH_TYPE;
            end
        end else if (pr_phase == PH_TYPE) begin
            if (b == CH_COMMA) begin
                pr_phase = PH_BODY;
            end else if (pr_len < 3'd3) begin
                pr_chars = {pr_chars[15:0], b};
                pr_len   = pr_len + 3'd1;
            end else begin
                pr_len = 3'd4;
            end
        end
        return 1'b0;
    endfunction

    // "$body*HH" plus CR LF, with the correct checksum
    function automatic string with_checksum(input string body, input bit lower);
        logic [7:0] sum;
        sum = 8'h00;
        for (int i = 0; i < body.len(); i++) begin
            sum = sum ^ body[i];
        end
        return $sformatf("$%s*%c%c\015\012", body, hex_char(sum[7:4], lower),
                         hex_char(sum[3:0], lower));
    endfunction

    function automatic logic [7:0] random_letter();
        return 8'h41 + 8'($urandom_range(25));
    endfunction

    function automatic logic [7:0] field_char();
        case ($urandom_range(4))
            0, 1:    return 8'h30 + 8'($urandom_range(9));
            2:       return random_letter();
            3:       return ".";
            default: return "-";
        endcase
    endfunction

    // Mostly well-formed sentence with random content, sometimes with one flaw
    task automatic make_random_sentence();
        logic [7:0]  body[$];
        logic [7:0]  sum;
        logic [15:0] talker;
        logic [23:0] tchars;
        int          n_fields;
        int          need;
        int          flaw;
        bit          lower;
        t_kind       k;
        body = {};
        case ($urandom_range(9))
            0, 5:    talker = "GP";
            1:       talker = "WT";
            2, 6:    talker = "GN";
            3:       talker = "GL";
            4:       talker = "IN";
            7:       talker = {8'h47, random_letter()};
            default: talker = {random_letter(), random_letter()};
        endcase
        body = {body, talker[15:8], talker[7:0]};

        // sentence type
        k = t_kind'(3'($urandom_range(1, 6)));
        case (k)
            KIND_GGA: tchars = "GGA";
            KIND_RTK: tchars = "RTK";
            KIND_RMC: tchars = "RMC";
            KIND_GST: tchars = "GST";
            KIND_HDT: tchars = "HDT";
            default:  tchars = "VTG";
        endcase
        case ($urandom_range(9))
            8: begin
                repeat ($urandom_range(1, 5)) body = {body, random_letter()};
                need = $urandom_range(1, 12);
            end
            9: begin
                repeat (3) body = {body, random_letter()};
                need = $urandom_range(1, 12);
            end
            default: begin
                body = {body, tchars[23:16], tchars[15:8], tchars[7:0]};
                need = fields_needed(k);
            end
        endcase

        // fields around the type's minimum, now and then any count from 1 to 75
        if ($urandom_range(19) == 0) begin
            n_fields = $urandom_range(1, 75);
        end else begin
            n_fields = need - 2 + $urandom_range(4);
        end
        for (int i = 1; i < n_fields; i++) begin
            body = {body, CH_COMMA};
            repeat ($urandom_range(3)) body = {body, field_char()};
        end

        flaw = $urandom_range(19);
        if (flaw == 0) begin
            body.insert($urandom_range(body.size() - 1), 8'($urandom_range(255)));
        end
        sum = 8'h00;
        foreach (body[i]) sum = sum ^ body[i];

        tx_q = {CH_DOLLAR};
        foreach (body[i]) tx_q = {tx_q, body[i]};
        if (flaw != 1) begin
            tx_q = {tx_q, CH_STAR};
            if (flaw == 2) begin
                sum = sum ^ 8'($urandom_range(1, 255));
            end
            lower = 1'($urandom_range(1));
            tx_q = {tx_q, hex_char(sum[7:4], lower)};
            if (flaw != 3) begin
                tx_q = {tx_q, hex_char(sum[3:0], lower)};
            end
            if (flaw == 4) begin
                tx_q = {tx_q, hex_char(4'($urandom_range(15)), lower)};
            end
            if (flaw == 5) begin
                tx_q = {tx_q, 8'($urandom_range(255))};
            end
        end
        // without an end the next '$' restarts the sentence
        if (flaw != 6) begin
            case ($urandom_range(2))
                0:       tx_q = {tx_q, CH_CR};
                1:       tx_q = {tx_q, CH_LF};
                default: begin
                    tx_q = {tx_q, CH_CR, CH_LF};
                end
            endcase
        end
    endtask

    // Offer one byte from a falling edge; returns at the falling edge after the beat
    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < snd_idle) begin
            rx_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        rx_if.valid   <= 1'b1;
        rx_if.rx_byte <= b;
        @(posedge i_clk);
        while (!rx_if.ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        rx_if.valid <= 1'b0;
        while (expected_reports.size() != 0) @(negedge i_clk);
    endtask

    // Receiver: random stalls, or a long hold-off on request
    always @(negedge i_clk) begin
        if (hold_left != 0) begin
            res_if.ready <= 1'b0;
            hold_left = hold_left - 1;
        end else if (hold_req != 0) begin
            res_if.ready <= 1'b0;
            hold_left = hold_req - 1;
            hold_req  = 0;
        end else begin
            res_if.ready <= ($urandom_range(99) >= rcv_idle);
        end
    end

    // Monitor: predict on every byte beat, check every report beat
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (rx_if.valid && rx_if.ready) begin
                bytes_taken++;
                if (parse_byte(rx_if.rx_byte, mon_pred)) begin
                    expected_reports = {expected_reports, (use_typed ? typed_exp : mon_pred)};
                end
            end
            if (res_if.valid && res_if.ready) begin
                reports_seen++;
                if (res_if.accepted) accepted_seen++;
                if (res_if.checksum_ok) sum_good_seen++;
                if (expected_reports.size() == 0) begin
                    failures++;
                    if (failures <= REPORT_LIMIT) begin
                        $display({"[%0d] unexpected report: fmt=%b sum=%b kind=%0d",
                                  " fields=%0d acc=%b xor=%h"},
                                 cycles, res_if.format_ok, res_if.checksum_ok,
                                 res_if.sentence_kind, res_if.field_total,
                                 res_if.accepted, res_if.computed_sum);
                    end
                end else begin
                    mon_want = expected_reports.pop_front();
                    if (res_if.format_ok     !== mon_want.format_ok    ||
                        res_if.checksum_ok   !== mon_want.checksum_ok  ||
                        res_if.sentence_kind !== mon_want.kind         ||
                        res_if.field_total   !== mon_want.field_total  ||
                        res_if.accepted      !== mon_want.accepted     ||
                        res_if.computed_sum  !== mon_want.computed_sum) begin
                        failures++;
                        if (failures <= REPORT_LIMIT) begin
                            $display({"[%0d] report mismatch: exp fmt=%b sum=%b kind=%0d",
                                      " fields=%0d acc=%b xor=%h"},
                                     cycles, mon_want.format_ok, mon_want.checksum_ok,
                                     mon_want.kind, mon_want.field_total,
                                     mon_want.accepted, mon_want.computed_sum);
                            $display({"[%0d]                 got fmt=%b sum=%b kind=%0d",
                                      " fields=%0d acc=%b xor=%h"},
                                     cycles, res_if.format_ok, res_if.checksum_ok,
                                     res_if.sentence_kind, res_if.field_total,
                                     res_if.accepted, res_if.computed_sum);
                        end
                    end
                end
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial begin
        string       s;
        logic [7:0]  b;
        int unsigned phase_bytes;
        i_rst_n       = 1'b0;
        rx_if.valid   = 1'b0;
        rx_if.rx_byte = 8'h00;
        res_if.ready  = 1'b0;

        // Directed cases; typed rows carry their report, the rest use the predictor
        dir_typed = '{default: 1'b0};
        dir_exp   = '{default: '0};
        dir_text[0] = "xy\015\012";
        dir_text[1] = "$\015";
        dir_typed[1] = 1'b1;
        dir_exp[1]   = '{format_ok: 1'b0, checksum_ok: 1'b0, kind: KIND_NONE,
                         field_total: 6'd1, accepted: 1'b0, computed_sum: 8'h00};
        dir_text[2] = "$*00\015";
        dir_typed[2] = 1'b1;
        dir_exp[2]   = '{format_ok: 1'b0, checksum_ok: 1'b1, kind: KIND_NONE,
                         field_total: 6'd1, accepted: 1'b0, computed_sum: 8'h00};
        dir_text[3] = "$*0g\012";
        dir_typed[3] = 1'b1;
        dir_exp[3]   = '{format_ok: 1'b0, checksum_ok: 1'b0, kind: KIND_NONE,
                         field_total: 6'd1, accepted: 1'b0, computed_sum: 8'h00};
        dir_text[4] = with_checksum("GPGGA,1,2,3,4,5,6,7,8,9,10,11", 1'b0);
        s = "GNRTK";
        repeat (25) s = {s, ",7"};
        dir_text[5]  = with_checksum(s, 1'b0);
        dir_text[6]  = with_checksum("GLRMC,a,b,c,d,e,f,g,h,i", 1'b1);
        dir_text[7]  = with_checksum("WTGST,1,2,3,4,5,6,7,8", 1'b0);
        dir_text[8]  = with_checksum("INHDT,1", 1'b1);
        dir_text[9]  = with_checksum("GPVTG,,,,,", 1'b0);
        dir_text[10] = with_checksum("GPGGA,1,2,3,4,5,6,7,8,9,10", 1'b0);
        dir_text[11] = with_checksum("XXGGA,1,2,3,4,5,6,7,8,9,10,11", 1'b0);
        dir_text[12] = with_checksum("GPGGAX,1", 1'b0);
        dir_text[13] = with_checksum("GPGG,1", 1'b0);
        dir_text[14] = {"$GPGG", with_checksum("GPHDT,3", 1'b0)};
        dir_text[15] = "$GPHDT,1*00\015";
        dir_text[16] = "$GPHDT,1*123\015";
        dir_text[17] = "$GPHDT,1*12,\015";
        dir_text[18] = "$GPGGA,1,2\015";
        s = "GPGGA";
        repeat (70) s = {s, ","};
        dir_text[19] = with_checksum(s, 1'b0);
        dir_text[20] = "$G*00\015";
        dir_text[21] = "$,\012";
        dir_text[22] = "$GP\001\377,\377*00\015\012";

        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        snd_idle = 37;
        rcv_idle = 88;
        for (int r = 0; r < DIR_N; r++) begin
            use_typed = dir_typed[r];
            typed_exp = dir_exp[r];
            for (int i = 0; i < dir_text[r].len(); i++) begin
                b = dir_text[r][i];
                if (b == CH_NUL_MARK) b = 8'h00;
                send_byte(b);
            end
        end
        use_typed = 1'b0;
        wait_drained();

        // Random streams under three idle profiles; the last one opens with a hold-off
        for (int ph = 0; ph < 3; ph++) begin
            case (ph)
                0: begin snd_idle = 37; rcv_idle = 88; end
                1: begin snd_idle = 88; rcv_idle = 37; end
                default: begin
                    snd_idle = 0;
                    rcv_idle = 0;
                    hold_req = HOLD_CYCLES;
                end
            endcase
            phase_bytes = 0;
            while (phase_bytes < BYTES_PER_PHASE) begin
                if ($urandom_range(6) == 0) begin
                    tx_q = {};
                    repeat ($urandom_range(1, 8)) tx_q = {tx_q, 8'($urandom_range(255))};
                end else begin
                    make_random_sentence();
                end
                foreach (tx_q[i]) send_byte(tx_q[i]);
                phase_bytes += tx_q.size();
            end
            wait_drained();
        end

        repeat (8) @(negedge i_clk);
        if (expected_reports.size() != 0) failures++;

        $display("Covered %0d byte beats and %0d sentence reports (%0d accepted, %0d sums ok)",
                 bytes_taken, reports_seen, accepted_seen, sum_good_seen);
        $display("Directed cases, three idle profiles, a %0d-cycle hold-off; %0d failures",
                 HOLD_CYCLES, failures);
        if (failures == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/core/nsc_pkg.sv
rtl/core/nsc_ifs.sv
rtl/core/nsc_parser.sv
rtl/core/nsc_report.sv
rtl/core/nmea_sentence_checker.sv
tb/sv/tb_nmea_sentence_checker.sv
